[design/ksel_pkg.sv]
// ----------------------------------------------------------------------------
// ksel_pkg
// shared types and constants for the k-smallest edge selector
// ----------------------------------------------------------------------------
package ksel_pkg;

  localparam int unsigned NODE_W   = 16;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned KEEP_W   = 7;

  // one kept edge as held by a cell
  typedef struct packed {
    logic                       valid;
    logic signed [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]          node_a;
    logic [NODE_W-1:0]          node_b;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '0;

  // per-cell step control
  typedef struct packed {
    logic insert;
    logic shift;
    logic in_range;
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage

[design/ksel_if.sv]
// ----------------------------------------------------------------------------
// ksel channel interfaces
// edge input, edge result and configuration write channels
// ----------------------------------------------------------------------------
interface ksel_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [ksel_pkg::NODE_W-1:0]           edge_from;
  logic [ksel_pkg::NODE_W-1:0]           edge_to;
  logic signed [ksel_pkg::WEIGHT_W-1:0]  edge_weight;
  logic                                  batch_end;

  modport source (output valid, edge_from, edge_to, edge_weight, batch_end, input ready);
  modport sink (input valid, edge_from, edge_to, edge_weight, batch_end, output ready);
endinterface

interface ksel_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [ksel_pkg::NODE_W-1:0]           out_from;
  logic [ksel_pkg::NODE_W-1:0]           out_to;
  logic signed [ksel_pkg::WEIGHT_W-1:0]  out_weight;
  logic                                  final_result;

  modport source (output valid, out_from, out_to, out_weight, final_result, input ready);
  modport sink (input valid, out_from, out_to, out_weight, final_result, output ready);
endinterface

interface ksel_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ksel_pkg::KEEP_W-1:0]   keep_count;

  modport source (output valid, keep_count, input ready);
  modport sink (input valid, keep_count, output ready);
endinterface

[design/ksel_cell.sv]
// ----------------------------------------------------------------------------
// ksel_cell
// one compare-and-shift cell of the sorted insertion chain
// ----------------------------------------------------------------------------
module ksel_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ksel_pkg::cell_ctrl_t ctrl,
  input  ksel_pkg::entry_t     new_e,
  input  ksel_pkg::entry_t     prev_e,
  input  logic                 prev_lt,
  output ksel_pkg::entry_t     cur_e,
  output logic                 lt
);

  ksel_pkg::entry_t ent_r;
  ksel_pkg::entry_t ent_nxt;

  // strictly smaller kept entry stays put, so equal weights go behind the new one
  assign lt = ent_r.valid && ctrl.in_range &&
              ($signed(ent_r.weight) < $signed(new_e.weight));

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.shift) begin
      ent_nxt = prev_e;
    end else if (ctrl.insert && !lt) begin
      if (prev_lt) begin
        ent_nxt = new_e;
      end else begin
        ent_nxt = prev_e;
      end
      ent_nxt.valid = ent_nxt.valid && ctrl.in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign cur_e = ent_r;

endmodule

[design/k_smallest_edges_by_weight.sv]
// ----------------------------------------------------------------------------
// k_smallest_edges_by_weight
// keeps the keep_count lightest edges of a batch and reports them on batch end
// ----------------------------------------------------------------------------
// an edge item is taken every cycle while a batch is being collected: it is
// broadcast to a row of MAX_KEEP compare-and-shift cells which insert it in
// place, lighter edges first, a newer edge ahead of older ones of equal
// weight. the item marked batch_end is inserted the same way, then input stalls
// while the row drains: every cycle in which the top cell is empty or its edge
// leaves, the row shifts one cell towards the top cell, first to bring the
// heaviest kept edge to the top, then one result per cycle for the n kept
// edges unless the output stalls, heaviest first, the lightest flagged
// final_result. no drain takes place when no edge is kept. keep_count above
// MAX_KEEP acts as MAX_KEEP and zero keeps nothing. the configuration channel
// is always ready.
// ----------------------------------------------------------------------------
module k_smallest_edges_by_weight #(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ksel_in_if.sink    in_edge,
  ksel_out_if.source out_edge,
  ksel_cfg_if.sink   cfg_wr
);

  localparam int unsigned KW = ksel_pkg::KEEP_W;
  localparam logic [KW-1:0] MAX_KEEP_V = KW'(MAX_KEEP);

  // control state
  ksel_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]    keep_count_r;
  logic [KW-1:0]    fill_r, fill_nxt;
  logic [KW-1:0]    drain_left_r, drain_left_nxt;

  // result register
  logic                                 out_valid_r, out_valid_nxt;
  logic [ksel_pkg::NODE_W-1:0]          out_from_r;
  logic [ksel_pkg::NODE_W-1:0]          out_to_r;
  logic signed [ksel_pkg::WEIGHT_W-1:0] out_weight_r;
  logic                                 out_final_r;

  // chain signals
  ksel_pkg::entry_t     cell_e [MAX_KEEP];
  ksel_pkg::cell_ctrl_t cell_ctrl [MAX_KEEP];
  logic [MAX_KEEP-1:0]  lt_v;
  ksel_pkg::entry_t     new_e;
  ksel_pkg::entry_t     top_e;

  logic          in_ready;
  logic          draining;
  logic          in_fire;
  logic          out_free;
  logic          emit;
  logic          shift_up;
  logic [KW-1:0] lim;
  logic [KW-1:0] fill_clip;
  logic [KW-1:0] fill_ins;

  // configuration: to be written only while idle; the user must keep to this, the block does not enforce it
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KW'(1);
    end else if (cfg_wr.valid) begin
      keep_count_r <= cfg_wr.keep_count;
    end
  end

  // effective limit, saturated to the row length
  assign lim = (keep_count_r > MAX_KEEP_V) ? MAX_KEEP_V : keep_count_r;

  // fill after clipping to the limit and after the insert that follows
  assign fill_clip = (fill_r > lim) ? lim : fill_r;
  assign fill_ins  = ((lim != '0) && (fill_clip < lim)) ? fill_clip + KW'(1) : fill_clip;

  // state machine outputs
  always_comb begin
    in_ready = 1'b0;
    draining = 1'b0;
    case (state_r)
      ksel_pkg::ST_COLLECT: in_ready = 1'b1;
      ksel_pkg::ST_DRAIN:   draining = 1'b1;
      default: begin
        in_ready = 1'b0;
        draining = 1'b0;
      end
    endcase
  end

  assign in_edge.ready = in_ready;
  assign in_fire       = in_edge.valid && in_ready;

  // drain: top cell feeds the result register, row moves up when the top is
  // empty or its edge leaves
  assign top_e    = cell_e[MAX_KEEP-1];
  assign out_free = !out_valid_r || out_edge.ready;
  assign emit     = draining && top_e.valid && out_free;
  assign shift_up = draining && (!top_e.valid || out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ksel_pkg::ST_COLLECT: begin
        if (in_fire && in_edge.batch_end && (fill_ins != '0)) begin
          state_nxt = ksel_pkg::ST_DRAIN;
        end
      end
      ksel_pkg::ST_DRAIN: begin
        if (emit && (drain_left_r == KW'(1))) begin
          state_nxt = ksel_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = ksel_pkg::ST_COLLECT;
    endcase
  end

  // fill and drain counters
  always_comb begin
    fill_nxt       = fill_r;
    drain_left_nxt = drain_left_r;
    if (in_fire) begin
      if (in_edge.batch_end) begin
        fill_nxt       = '0;
        drain_left_nxt = fill_ins;
      end else begin
        fill_nxt = fill_ins;
      end
    end else if (emit) begin
      drain_left_nxt = drain_left_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ksel_pkg::ST_COLLECT;
      fill_r       <= '0;
      drain_left_r <= '0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      drain_left_r <= drain_left_nxt;
    end
  end

  // new edge broadcast to every cell
  always_comb begin
    new_e        = ksel_pkg::ENTRY_EMPTY;
    new_e.valid  = 1'b1;
    new_e.weight = in_edge.edge_weight;
    new_e.node_a = in_edge.edge_from;
    new_e.node_b = in_edge.edge_to;
  end

  // the row of cells
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    localparam logic [KW-1:0] CELL_IDX = KW'(i);
    ksel_pkg::entry_t prev_e;
    logic             prev_lt;

    if (i == 0) begin : g_head
      assign prev_e  = ksel_pkg::ENTRY_EMPTY;
      assign prev_lt = 1'b1;
    end else begin : g_link
      assign prev_e  = cell_e[i-1];
      assign prev_lt = lt_v[i-1];
    end

    always_comb begin
      cell_ctrl[i].insert   = in_fire;
      cell_ctrl[i].shift    = shift_up;
      cell_ctrl[i].in_range = (CELL_IDX < lim);
    end

    ksel_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl[i]),
      .new_e   (new_e),
      .prev_e  (prev_e),
      .prev_lt (prev_lt),
      .cur_e   (cell_e[i]),
      .lt      (lt_v[i])
    );
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_edge.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_from_r   <= top_e.node_a;
      out_to_r     <= top_e.node_b;
      out_weight_r <= top_e.weight;
      out_final_r  <= (drain_left_r == KW'(1));
    end
  end

  assign out_edge.valid        = out_valid_r;
  assign out_edge.out_from     = out_from_r;
  assign out_edge.out_to       = out_to_r;
  assign out_edge.out_weight   = out_weight_r;
  assign out_edge.final_result = out_final_r;

`ifndef SYNTHESIS
  // an edge only leaves the row while some are still owed
  a_emit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (drain_left_r != '0))
    else $error("edge emitted with nothing left to drain");

  // fill count never passes the row length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_KEEP_V)
    else $error("fill count beyond row length");

  // the last edge of a batch returns the block to collecting with an empty top
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (drain_left_r == KW'(1))) |=>
      ((state_r == ksel_pkg::ST_COLLECT) && !cell_e[MAX_KEEP-1].valid))
    else $error("row not empty after final item");

  // input is held off for the whole drain
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_left_r != '0) && (state_r == ksel_pkg::ST_DRAIN) |-> !in_fire)
    else $error("edge taken during drain");
`endif

endmodule

[tb/sv/k_smallest_edges_by_weight_test.sv]
// ----------------------------------------------------------------------------
// k_smallest_edges_by_weight_test
// self-checking bench for the k-smallest edge selector: edges stream in over
// the input channel with random gaps, a scoreboard keeps its own sorted list
// of the lightest edges and queues the edges each batch end should report,
// and the result channel is drained with random back-pressure and compared
// item by item. keep_count is changed between phases, mid-batch as well.
// ----------------------------------------------------------------------------
module k_smallest_edges_by_weight_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEEP_MAX     = 64;
  localparam int unsigned KW           = ksel_pkg::KEEP_W;
  localparam int unsigned GAP_MAX      = 18;
  localparam int unsigned SETTLE       = KEEP_MAX + 16;
  localparam int unsigned CYCLE_CAP    = 500000;
  localparam int unsigned RANDOM_ITEMS = 280;

  // one edge, used both for an input item and for a reported result
  // (last is batch_end on the way in and final_result on the way out)
  typedef struct packed {
    logic [ksel_pkg::NODE_W-1:0]          node_from;
    logic [ksel_pkg::NODE_W-1:0]          node_to;
    logic signed [ksel_pkg::WEIGHT_W-1:0] weight;
    logic                                 last;
  } edge_t;

  // how the weights of a random batch are spread
  typedef enum int unsigned {
    W_SPREAD,   // full 32-bit range
    W_CLUSTER,  // a handful of values, lots of ties
    W_EXTREME   // most positive, most negative, zero and minus one
  } weight_mix_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the kept list and holds the edges still to be reported
  // --------------------------------------------------------------------------
  class edge_rank_board;
    logic [ksel_pkg::KEEP_W-1:0] keep_count;
    edge_t                       kept_edges[$];   // lightest first
    edge_t                       due_results[$];  // oldest first
    int unsigned                 mismatches;

    function new();
      keep_count = KW'(1);
      mismatches = 0;
    endfunction

    function void set_keep(logic [ksel_pkg::KEEP_W-1:0] value);
      keep_count = value;
    endfunction

    // insert an accepted edge and, on batch end, queue the kept edges
    function void note_edge(edge_t e);
      int unsigned lim;
      int unsigned pos;
      edge_t       r;
      lim = (32'(keep_count) > KEEP_MAX) ? KEEP_MAX : 32'(keep_count);
      // a lowered limit cuts the heaviest entries first
      while (kept_edges.size() > lim) void'(kept_edges.pop_back());
      if (lim > 0) begin
        pos = 0;
        // strictly lighter entries stay ahead, so a newer tie goes in front
        while (pos < kept_edges.size() && kept_edges[pos].weight < e.weight) pos++;
        if (pos < lim) begin
          kept_edges.insert(pos, e);
          if (kept_edges.size() > lim) void'(kept_edges.pop_back());
        end
      end
      if (e.last) begin
        // heaviest kept first, the lightest carries the final flag
        for (int i = int'(kept_edges.size()) - 1; i >= 0; i--) begin
          r = kept_edges[i];
          r.last = (i == 0);
          due_results.push_back(r);
        end
        kept_edges.delete();
      end
    endfunction

    function void check_edge(edge_t got);
      edge_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected edge from=%h to=%h weight=%0d final=%b",
                 $time, got.node_from, got.node_to, got.weight, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.node_from !== want.node_from || got.node_to !== want.node_to ||
          got.weight !== want.weight || got.last !== want.last) begin
        mismatches++;
        $display("%0t: edge mismatch, expected from=%h to=%h weight=%0d final=%b",
                 $time, want.node_from, want.node_to, want.weight, want.last);
        $display("%0t:                actual   from=%h to=%h weight=%0d final=%b",
                 $time, got.node_from, got.node_to, got.weight, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  ksel_in_if  in_ch ();
  ksel_out_if out_ch ();
  ksel_cfg_if cfg_ch ();

  edge_rank_board board = new();

  // per-phase switches that turn idling off on either side
  bit          in_steady;
  bit          out_steady;
  int unsigned sent;
  int unsigned cycles;

  k_smallest_edges_by_weight #(
    .MAX_KEEP(KEEP_MAX)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_edge (in_ch),
    .out_edge(out_ch),
    .cfg_wr  (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog, generous against the slowest legal run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("%0t: timeout with %0d edges still outstanding", $time,
               board.due_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driving tasks: called and returning at a falling edge
  // --------------------------------------------------------------------------
  function automatic edge_t pack_edge(logic [15:0] a, logic [15:0] b,
                                      logic signed [31:0] w, logic last);
    edge_t e;
    e.node_from = a;
    e.node_to   = b;
    e.weight    = w;
    e.last      = last;
    return e;
  endfunction

  function automatic edge_t random_edge(weight_mix_t mix, logic last);
    logic signed [31:0] extremes[4];
    logic signed [31:0] w;
    extremes = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff};
    case (mix)
      W_SPREAD:  w = $urandom;
      W_CLUSTER: w = int'($urandom_range(0, 8)) - 4;
      default:   w = extremes[$urandom_range(0, 3)];
    endcase
    return pack_edge(16'($urandom), 16'($urandom), w, last);
  endfunction

  // valid stays high across back-to-back items, it only drops for a gap or while the bench drains
  task automatic send_edge(input edge_t e);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.edge_from   = e.node_from;
    in_ch.edge_to     = e.node_to;
    in_ch.edge_weight = e.weight;
    in_ch.batch_end   = e.last;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_edge(e);
    sent++;
    @(negedge clk);
  endtask

  // hold the input until every queued edge is out, then let the row settle
  task automatic drain_and_settle();
    in_ch.valid = 1'b0;
    while (board.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic change_keep(input logic [ksel_pkg::KEEP_W-1:0] value);
    drain_and_settle();
    cfg_ch.keep_count = value;
    cfg_ch.valid      = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_keep(value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall before each item, checked at the rising edge
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    edge_t       got;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.node_from = out_ch.out_from;
      got.node_to   = out_ch.out_to;
      got.weight    = out_ch.out_weight;
      got.last      = out_ch.final_result;
      board.check_edge(got);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned                 keep_plan[6];
    logic [ksel_pkg::KEEP_W-1:0] kv;
    int unsigned                 lim;
    int unsigned                 len;
    int unsigned                 batches;
    int unsigned                 phase;
    int unsigned                 random_end;
    weight_mix_t                 mix;

    keep_plan = '{64, 1, 127, 0, 65, 2};
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.edge_from   = '0;
    in_ch.edge_to     = '0;
    in_ch.edge_weight = '0;
    in_ch.batch_end   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.keep_count = '0;
    in_steady         = 1'b0;
    out_steady        = 1'b0;
    sent              = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset keeps one edge: only the lightest comes back
    send_edge(pack_edge(16'h0001, 16'h0002, 32'sd0, 1'b0));
    send_edge(pack_edge(16'h0003, 16'h0004, -32'sd1, 1'b0));
    send_edge(pack_edge(16'h0005, 16'h0006, 32'sd5, 1'b1));

    // extreme weights and node numbers, three-way tie closed by the batch end
    change_keep(KW'(4));
    send_edge(pack_edge(16'hffff, 16'h0000, 32'sh7fffffff, 1'b0));
    send_edge(pack_edge(16'h0000, 16'hffff, 32'sh80000000, 1'b0));
    send_edge(pack_edge(16'h0001, 16'h0001, 32'sd7, 1'b0));
    send_edge(pack_edge(16'h0002, 16'h0002, 32'sd7, 1'b0));
    send_edge(pack_edge(16'h0003, 16'h0003, 32'sd7, 1'b1));

    // fewer edges than keep_count
    send_edge(pack_edge(16'haaaa, 16'h5555, 32'sd100, 1'b0));
    send_edge(pack_edge(16'h5555, 16'haaaa, -32'sd100, 1'b1));

    // nothing kept: batch end reports nothing but still closes the batch
    change_keep(KW'(0));
    send_edge(pack_edge(16'h0001, 16'h0002, 32'sd3, 1'b0));
    send_edge(pack_edge(16'h0004, 16'h0005, 32'sd6, 1'b1));

    // keep_count beyond the row saturates
    change_keep(KW'(100));
    send_edge(pack_edge(16'h0010, 16'h0011, -32'sd5, 1'b0));
    send_edge(pack_edge(16'h0012, 16'h0013, -32'sd5, 1'b0));
    send_edge(pack_edge(16'h0014, 16'h0015, 32'sd0, 1'b1));

    // limit lowered in the middle of a batch drops the heaviest
    change_keep(KW'(5));
    repeat (4) send_edge(random_edge(W_SPREAD, 1'b0));
    change_keep(KW'(2));
    send_edge(random_edge(W_SPREAD, 1'b1));

    // limit raised mid-batch: dropped edges stay lost
    change_keep(KW'(1));
    repeat (2) send_edge(random_edge(W_CLUSTER, 1'b0));
    change_keep(KW'(3));
    send_edge(random_edge(W_CLUSTER, 1'b1));

    // random phases, each with its own keep_count and idling pattern
    random_end = sent + RANDOM_ITEMS;
    phase = 0;
    while (sent < random_end) begin
      if (phase < 6) kv = KW'(keep_plan[phase]);
      else if ($urandom_range(0, 3) == 0) kv = KW'($urandom_range(0, 127));
      else kv = KW'($urandom_range(1, 8));
      change_keep(kv);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      lim = (32'(kv) > KEEP_MAX) ? KEEP_MAX : 32'(kv);
      // wide settings get one long batch, narrow ones several short ones
      batches = (lim > 8) ? 1 : $urandom_range(2, 5);
      repeat (batches) begin
        len = $urandom_range(1, lim + 3);
        mix = weight_mix_t'($urandom_range(0, 2));
        for (int i = 0; i < len; i++) send_edge(random_edge(mix, i == len - 1));
      end
      // sometimes leave a batch open across the next keep_count change
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_edge(random_edge(W_SPREAD, 1'b0));
      phase++;
    end
    // close whatever batch is still open
    send_edge(random_edge(W_SPREAD, 1'b1));

    drain_and_settle();
    if (board.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
